@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, each on a rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/srpg_pkg.sv @@
// ----------------------------------------------------------------------------
// srpg_pkg
// Types, codes and reset values of the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srpg_pkg;

  localparam int PULSES_PER_CHECK = 16;
  localparam int PERIOD_WIDTH     = 10;

  localparam int TARGET_WIDTH   = 10;
  localparam int SETUP_WIDTH    = 8;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 10;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_FASTER = 2'd3
  } action_e;

  typedef struct packed {
    action_e action;
    logic    direction_cw;
  } in_item_t;

  typedef struct packed {
    logic                    step_level;
    logic                    dir_level;
    logic                    generator_active;
    logic                    requested_running;
    logic [TARGET_WIDTH-1:0] target_half_period;
    logic                    refused;
  } out_item_t;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEFAULT_HALF_PERIOD = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_HALF_PERIOD   = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RAMP_DECREMENT      = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_HALF_PERIOD     = CFG_IDX_WIDTH'(3);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DIR_SETUP_US        = CFG_IDX_WIDTH'(4);

  localparam logic [TARGET_WIDTH-1:0] RST_DEFAULT_HALF_PERIOD = 10'd50;
  localparam logic [TARGET_WIDTH-1:0] RST_START_HALF_PERIOD   = 10'd50;
  localparam logic [TARGET_WIDTH-1:0] RST_RAMP_DECREMENT      = 10'd10;
  localparam logic [TARGET_WIDTH-1:0] RST_MIN_HALF_PERIOD     = 10'd5;
  localparam logic [SETUP_WIDTH-1:0]  RST_DIR_SETUP_US        = 8'd5;

endpackage

`default_nettype wire

@@ rtl/srpg_if.sv @@
// ----------------------------------------------------------------------------
// srpg_if
// Valid/ready stream interfaces for the input and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srpg_in_if;
  logic               valid;
  logic               ready;
  srpg_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srpg_out_if;
  logic                valid;
  logic                ready;
  srpg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/stepper_ramp_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Step and direction generator for a stepper motor with a linear speed ramp.
// ----------------------------------------------------------------------------
// Each input transaction is either a one-microsecond tick or a command (start,
// stop, faster), and each one yields exactly one result transaction carrying
// the step and direction levels and the requested state after it. Commands
// update the requested state at once; the generator itself moves only on
// ticks and samples stop, direction and target at check points, namely the
// first pulse of a run and then every PULSES_PER_CHECK+1 pulses. The block
// takes one transaction per clock cycle while the result channel does not
// stall. A transaction sits in the input register while the next-state logic
// works on it, and the result register captures the outcome and offers it.
// The next-state logic holds a counter increment, a compare against the
// half-period and the ramp subtraction. The user must see that configuration
// registers are written through the plain write port only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepper_ramp_pulse_generator #(
  parameter int PULSES_PER_CHECK = srpg_pkg::PULSES_PER_CHECK,
  parameter int PERIOD_WIDTH     = srpg_pkg::PERIOD_WIDTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  srpg_in_if.sink                                  in_i,
  srpg_out_if.source                               out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [srpg_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  wire logic [srpg_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i
);

  localparam int TGW = srpg_pkg::TARGET_WIDTH;
  localparam int SUW = srpg_pkg::SETUP_WIDTH;
  localparam int PW  = PERIOD_WIDTH;
  // Wide enough to compare a period value against a 10-bit register.
  localparam int CW  = (PW > TGW) ? PW : TGW;
  // The time counter serves both the half-period and the setup hold.
  localparam int TW  = (PW > SUW) ? PW : SUW;
  localparam int PCW = (PULSES_PER_CHECK < 2) ? 1 : $clog2(PULSES_PER_CHECK + 1);

  // Generator phase codes.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SETUP = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_LOW   = 2'd3;

  // The whole pulse generator state, kept together so that the pulse start
  // step can be written once and reused from several phases.
  typedef struct packed {
    logic [1:0]     phase;
    logic           cw;
    logic           dir;
    logic           setup_checks;
    logic [PW-1:0]  target;
    logic [PW-1:0]  half;
    logic [TW-1:0]  time_cnt;
    logic [PCW-1:0] pulses;
  } gen_t;

  // Configuration registers.
  logic [TGW-1:0] default_hp_q;
  logic [TGW-1:0] start_hp_q;
  logic [TGW-1:0] ramp_dec_q;
  logic [TGW-1:0] min_hp_q;
  logic [SUW-1:0] dir_setup_q;

  // Requested state, changed by commands.
  logic           req_running_q, req_running_d;
  logic           req_cw_q, req_cw_d;
  logic [TGW-1:0] req_target_q, req_target_d;

  gen_t gen_q, gen_d, gen_tick;

  // Input register and result register.
  logic                in_valid_q;
  srpg_pkg::in_item_t  in_data_q;
  logic                out_valid_q;
  srpg_pkg::out_item_t out_data_q, out_data_d;

  logic in_ready;
  logic out_free;
  logic exec;
  logic refused;

  // Masked and widened copies of the registers.
  logic [CW-1:0]  start_w, req_w, def_w, fast_w, def_back_w, fast_back_w;
  logic [PW-1:0]  start_m, req_m, def_m, fast_m;
  logic [TGW-1:0] halved, fast_raw;
  logic [CW-1:0]  half_w, tgt_w, ramp_w, diff_w, sub_w;
  logic [PW-1:0]  ramped;
  logic [TW-1:0]  time_inc, setup_ext, half_ext;
  logic           setup_zero;

  // Start of a pulse. At a check point this applies a pending stop, picks up
  // the target and, on a direction change, restarts the ramp and, unless the
  // setup hold is zero, restarts the setup hold instead of raising the step pin.
  function automatic gen_t begin_pulse(gen_t s, logic run, logic cw,
                                       logic [PW-1:0] tgt, logic [PW-1:0] start,
                                       logic zero_setup);
    gen_t r;
    r          = s;
    r.phase    = PH_HIGH;
    r.time_cnt = '0;
    if (s.pulses >= PCW'(PULSES_PER_CHECK)) begin
      r.pulses = '0;
      if (!run) begin
        r.phase = PH_IDLE;
      end else begin
        r.target = tgt;
        if (cw != s.cw) begin
          r.cw   = cw;
          r.dir  = !cw;
          r.half = start;
          if (!zero_setup) begin
            r.phase        = PH_SETUP;
            r.setup_checks = 1'b0;
          end
        end
      end
    end else begin
      r.pulses = s.pulses + PCW'(1);
    end
    return r;
  endfunction

  // Handshake: the input register refills whenever its content moves on, and
  // the result register takes a new result whenever the old one is gone.
  assign out_free   = !out_valid_q || out_o.ready;
  assign exec       = in_valid_q && out_free;
  assign in_ready   = !in_valid_q || out_free;
  assign in_i.ready = in_ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Period values are held in PERIOD_WIDTH bits, so registers are masked to
  // that width where they enter the generator or the requested target.
  always_comb begin
    start_w     = CW'(start_hp_q);
    start_m     = start_w[PW-1:0];
    req_w       = CW'(req_target_q);
    req_m       = req_w[PW-1:0];
    def_w       = CW'(default_hp_q);
    def_m       = def_w[PW-1:0];
    def_back_w  = CW'(def_m);
    halved      = req_target_q >> 1;
    fast_raw    = (halved < min_hp_q) ? min_hp_q : halved;
    fast_w      = CW'(fast_raw);
    fast_m      = fast_w[PW-1:0];
    fast_back_w = CW'(fast_m);
  end

  // Ramp step: the half-period falls by the decrement but never below the
  // generator target; a half-period already below the target is kept.
  always_comb begin
    half_w = CW'(gen_q.half);
    tgt_w  = CW'(gen_q.target);
    ramp_w = CW'(ramp_dec_q);
    diff_w = half_w - tgt_w;
    sub_w  = half_w - ramp_w;
    ramped = gen_q.half;
    if (half_w > tgt_w) begin
      if (diff_w < ramp_w) begin
        ramped = gen_q.target;
      end else begin
        ramped = sub_w[PW-1:0];
      end
    end
  end

  // Generator advance for one tick.
  always_comb begin
    time_inc   = gen_q.time_cnt + TW'(1);
    setup_ext  = TW'(dir_setup_q);
    half_ext   = TW'(gen_q.half);
    setup_zero = (dir_setup_q == '0);
    gen_tick   = gen_q;
    unique case (gen_q.phase)
      PH_IDLE: begin
        // Launch on the first tick that sees a run requested.
        if (req_running_q) begin
          gen_tick.cw       = req_cw_q;
          gen_tick.dir      = !req_cw_q;
          gen_tick.target   = req_m;
          gen_tick.half     = start_m;
          gen_tick.pulses   = PCW'(PULSES_PER_CHECK);
          gen_tick.time_cnt = '0;
          if (setup_zero) begin
            gen_tick = begin_pulse(gen_tick, req_running_q, req_cw_q, req_m,
                                   start_m, setup_zero);
          end else begin
            gen_tick.phase        = PH_SETUP;
            gen_tick.setup_checks = 1'b1;
          end
        end
      end
      PH_SETUP: begin
        gen_tick.time_cnt = time_inc;
        if (time_inc >= setup_ext) begin
          if (gen_q.setup_checks) begin
            gen_tick = begin_pulse(gen_tick, req_running_q, req_cw_q, req_m,
                                   start_m, setup_zero);
          end else begin
            gen_tick.phase    = PH_HIGH;
            gen_tick.time_cnt = '0;
          end
        end
      end
      PH_HIGH: begin
        gen_tick.time_cnt = time_inc;
        if (time_inc >= half_ext) begin
          gen_tick.phase    = PH_LOW;
          gen_tick.time_cnt = '0;
        end
      end
      PH_LOW: begin
        gen_tick.time_cnt = time_inc;
        if (time_inc >= half_ext) begin
          gen_tick.half = ramped;
          gen_tick      = begin_pulse(gen_tick, req_running_q, req_cw_q, req_m,
                                      start_m, setup_zero);
        end
      end
      default: begin
        gen_tick = gen_q;
      end
    endcase
  end

  // Command handling and the result of the current transaction.
  always_comb begin
    req_running_d = req_running_q;
    req_cw_d      = req_cw_q;
    req_target_d  = req_target_q;
    gen_d         = gen_q;
    refused       = 1'b0;
    unique case (in_data_q.action)
      srpg_pkg::ACT_TICK: begin
        gen_d = gen_tick;
      end
      srpg_pkg::ACT_START: begin
        if (!req_running_q) begin
          req_target_d = def_back_w[TGW-1:0];
        end
        req_cw_d      = in_data_q.direction_cw;
        req_running_d = 1'b1;
      end
      srpg_pkg::ACT_STOP: begin
        req_running_d = 1'b0;
      end
      srpg_pkg::ACT_FASTER: begin
        if (!req_running_q) begin
          refused = 1'b1;
        end else begin
          req_target_d = fast_back_w[TGW-1:0];
        end
      end
      default: begin
        gen_d = gen_q;
      end
    endcase

    out_data_d.step_level         = (gen_d.phase == PH_HIGH);
    out_data_d.dir_level          = gen_d.dir;
    out_data_d.generator_active   = (gen_d.phase != PH_IDLE);
    out_data_d.requested_running  = req_running_d;
    out_data_d.target_half_period = req_target_d;
    out_data_d.refused            = refused;
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_data_q <= in_i.data;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_data_q <= out_data_d;
    end
  end

  // Requested and generator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_running_q <= 1'b0;
      req_cw_q      <= 1'b1;
      req_target_q  <= srpg_pkg::RST_DEFAULT_HALF_PERIOD;
      gen_q         <= '{phase:        PH_IDLE,
                         cw:           1'b1,
                         dir:          1'b0,
                         setup_checks: 1'b0,
                         target:       PW'(50),
                         half:         PW'(50),
                         time_cnt:     '0,
                         pulses:       PCW'(PULSES_PER_CHECK)};
    end else if (exec) begin
      req_running_q <= req_running_d;
      req_cw_q      <= req_cw_d;
      req_target_q  <= req_target_d;
      gen_q         <= gen_d;
    end
  end

  // Configuration registers; writes to an unused index are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_hp_q <= srpg_pkg::RST_DEFAULT_HALF_PERIOD;
      start_hp_q   <= srpg_pkg::RST_START_HALF_PERIOD;
      ramp_dec_q   <= srpg_pkg::RST_RAMP_DECREMENT;
      min_hp_q     <= srpg_pkg::RST_MIN_HALF_PERIOD;
      dir_setup_q  <= srpg_pkg::RST_DIR_SETUP_US;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srpg_pkg::CFG_DEFAULT_HALF_PERIOD: default_hp_q <= cfg_data_i[TGW-1:0];
        srpg_pkg::CFG_START_HALF_PERIOD:   start_hp_q   <= cfg_data_i[TGW-1:0];
        srpg_pkg::CFG_RAMP_DECREMENT:      ramp_dec_q   <= cfg_data_i[TGW-1:0];
        srpg_pkg::CFG_MIN_HALF_PERIOD:     min_hp_q     <= cfg_data_i[TGW-1:0];
        srpg_pkg::CFG_DIR_SETUP_US:        dir_setup_q  <= cfg_data_i[SUW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/srpg_checker.sv @@
// ----------------------------------------------------------------------------
// srpg_checker
// Port-level assertions for the stepper ramp pulse generator, with binding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srpg_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire srpg_pkg::out_item_t out_data_i
);

  // A stalled result transaction stays offered and unchanged.
  `ASSERT_NEXT_CYCLE(a_out_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT_CYCLE(a_out_data_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))

  // The step pin can only be high while the generator runs.
  `ASSERT_SAME_CYCLE(a_step_needs_active, clk_i, rst_ni, out_valid_i && out_data_i.step_level, out_data_i.generator_active)

  // A refused faster command leaves no run requested.
  `ASSERT_SAME_CYCLE(a_refused_when_idle, clk_i, rst_ni, out_valid_i && out_data_i.refused, !out_data_i.requested_running)

endmodule

bind stepper_ramp_pulse_generator srpg_checker u_srpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
